@@ sv/aabb_circle_collision_defines.svh @@
// Assertion macros for aabb_circle_collision.sv, which checks its own logic.
`ifndef AABB_CIRCLE_COLLISION_DEFINES_SVH
`define AABB_CIRCLE_COLLISION_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define ACC_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ACC_CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/acc_pkg.sv @@
package acc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 31;
	localparam int EXT_W     = 29;
	localparam int DEPTH_W   = 31;
	localparam int NORM_W    = 18;

	// Square root: one root bit per cell, the radicand is below 2^(2*LEN_W).
	localparam int LEN_W     = 29;
	localparam int RAD_W     = 2 * LEN_W;
	localparam int REM_W     = LEN_W + 2;
	// Division: one quotient bit per cell, the quotient never exceeds 2^FRAC_BITS.
	localparam int Q_BITS    = FRAC_BITS + 1;
	localparam int NUM_W     = LEN_W + Q_BITS;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_BITS);

	typedef struct packed {
		logic                      hit;
		logic                      interior;
		logic                      neg_x;
		logic                      neg_y;
		logic [LEN_W-1:0]          adx;
		logic [LEN_W-1:0]          ady;
		logic [EXT_W-1:0]          radius;
		logic [LEN_W-1:0]          len;
		logic [DEPTH_W-1:0]        in_depth;
		logic signed [NORM_W-1:0]  in_nx;
		logic signed [NORM_W-1:0]  in_ny;
	} tag_t;

endpackage

@@ sv/acc_sqrt_cell.sv @@
module acc_sqrt_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [acc_pkg::REM_W-1:0]  rem_in,
	input  logic [acc_pkg::LEN_W-1:0]  root_in,
	input  logic [acc_pkg::RAD_W-1:0]  rad_in,
	output logic [acc_pkg::REM_W-1:0]  rem_out,
	output logic [acc_pkg::LEN_W-1:0]  root_out,
	output logic [acc_pkg::RAD_W-1:0]  rad_out
);
	import acc_pkg::*;

	logic [REM_W+1:0] part;
	logic [REM_W+1:0] trial;
	logic             take;

	// Bring down the next two radicand bits and try the next root bit.
	assign part  = {rem_in, rad_in[RAD_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_in, 2'b01});
	assign take  = part >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? REM_W'(part - trial) : REM_W'(part);
			root_out <= {root_in[LEN_W-2:0], take};
			rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
		end
	end

endmodule

@@ sv/acc_div_cell.sv @@
module acc_div_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [acc_pkg::LEN_W-1:0]   divisor_in,
	input  logic [acc_pkg::LEN_W-1:0]   rem_in,
	input  logic [acc_pkg::Q_BITS-1:0]  low_in,
	input  logic [acc_pkg::Q_BITS-1:0]  quot_in,
	output logic [acc_pkg::LEN_W-1:0]   divisor_out,
	output logic [acc_pkg::LEN_W-1:0]   rem_out,
	output logic [acc_pkg::Q_BITS-1:0]  low_out,
	output logic [acc_pkg::Q_BITS-1:0]  quot_out
);
	import acc_pkg::*;

	logic [LEN_W:0] part;
	logic           take;

	// Restoring step: shift in the next numerator bit and subtract if it fits.
	assign part = {rem_in, low_in[Q_BITS-1]};
	assign take = part >= {1'b0, divisor_in};

	always_ff @(posedge clk) begin
		if (en) begin
			divisor_out <= divisor_in;
			rem_out     <= take ? LEN_W'(part - {1'b0, divisor_in}) : LEN_W'(part);
			low_out     <= {low_in[Q_BITS-2:0], 1'b0};
			quot_out    <= {quot_in[Q_BITS-2:0], take};
		end
	end

endmodule

@@ sv/aabb_circle_collision.sv @@
// Registers from an accepted input word to its result word, in order:
// 3 setup stages, 29 square-root cells, 1 stage, 17 divider cells, output.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output.
// Reset: arst_n clears all valid flags asynchronously; payload is not reset.
`include "aabb_circle_collision_defines.svh"

module aabb_circle_collision (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// From bit 0 up: box_center_x[31], box_center_y[31], box_half_width[29],
	// box_half_height[29], circle_center_x[31], circle_center_y[31],
	// circle_radius[29], zero fill[5].
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0 up: depth[31], normal_x[18], normal_y[18], zero fill[5].
	output logic [71:0]  m_tdata,
	// Bit 0: hit.
	output logic [0:0]   m_tuser
);
	import acc_pkg::*;

	localparam int DIV_CELLS = Q_BITS;
	localparam int SQ_CELLS  = LEN_W;

	// One enable for every stage: move when the output word is free or taken.
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	// ---------------- Stage 1: box edges, clamp, face selection ----------------
	logic signed [COORD_W-1:0] bcx, bcy, ccx, ccy;
	logic [EXT_W-1:0]          hw, hh, rad;
	assign bcx = s_tdata[30:0];
	assign bcy = s_tdata[61:31];
	assign hw  = s_tdata[90:62];
	assign hh  = s_tdata[119:91];
	assign ccx = s_tdata[150:120];
	assign ccy = s_tdata[181:151];
	assign rad = s_tdata[210:182];

	// Edges fit in 32 bits for every input, so no saturation is ever needed.
	logic signed [31:0] xlo, xhi, ylo, yhi, cx32, cy32, clx, cly;
	assign cx32 = 32'(ccx);
	assign cy32 = 32'(ccy);
	assign xlo  = 32'(bcx) - $signed({3'b000, hw});
	assign xhi  = 32'(bcx) + $signed({3'b000, hw});
	assign ylo  = 32'(bcy) - $signed({3'b000, hh});
	assign yhi  = 32'(bcy) + $signed({3'b000, hh});
	assign clx  = (cx32 < xlo) ? xlo : ((cx32 > xhi) ? xhi : cx32);
	assign cly  = (cy32 < ylo) ? ylo : ((cy32 > yhi) ? yhi : cy32);

	logic signed [32:0] dx, dy;
	logic [31:0]        adx_c, ady_c;
	assign dx    = 33'(cx32) - 33'(clx);
	assign dy    = 33'(cy32) - 33'(cly);
	assign adx_c = dx[32] ? 32'(-dx) : dx[31:0];
	assign ady_c = dy[32] ? 32'(-dy) : dy[31:0];

	// Nearest face for a center inside the box; earlier faces win ties.
	logic signed [32:0] f0, f1, f2, f3, fbest;
	logic signed [NORM_W-1:0] fnx, fny;
	logic [33:0] fsum;
	assign f0 = 33'(cx32) - 33'(xlo);
	assign f1 = 33'(xhi) - 33'(cx32);
	assign f2 = 33'(cy32) - 33'(ylo);
	assign f3 = 33'(yhi) - 33'(cy32);

	always_comb begin
		fbest = f0;
		fnx   = -NORM_ONE;
		fny   = '0;
		if (f1 < fbest) begin
			fbest = f1;
			fnx   = NORM_ONE;
			fny   = '0;
		end
		if (f2 < fbest) begin
			fbest = f2;
			fnx   = '0;
			fny   = -NORM_ONE;
		end
		if (f3 < fbest) begin
			fbest = f3;
			fnx   = '0;
			fny   = NORM_ONE;
		end
	end
	assign fsum = {1'b0, fbest} + 34'(rad);

	logic [31:0] adx_s1, ady_s1;
	tag_t        tag_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			adx_s1            <= adx_c;
			ady_s1            <= ady_c;
			tag_s1.hit        <= 1'b0;
			tag_s1.interior   <= 1'b0;
			tag_s1.neg_x      <= dx[32];
			tag_s1.neg_y      <= dy[32];
			tag_s1.adx        <= adx_c[LEN_W-1:0];
			tag_s1.ady        <= ady_c[LEN_W-1:0];
			tag_s1.radius     <= rad;
			tag_s1.len        <= '0;
			tag_s1.in_depth   <= (fsum > 34'(DEPTH_MAX)) ? DEPTH_MAX : fsum[DEPTH_W-1:0];
			tag_s1.in_nx      <= fnx;
			tag_s1.in_ny      <= fny;
		end
	end

	// ---------------- Stage 2: squares ----------------
	logic [63:0]      sqx_c, sqy_c, sqx_s2, sqy_s2;
	logic [RAD_W-1:0] rsq_c, rsq_s2;
	tag_t             tag_s2;
	assign sqx_c = adx_s1 * adx_s1;
	assign sqy_c = ady_s1 * ady_s1;
	assign rsq_c = tag_s1.radius * tag_s1.radius;
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= sqx_c;
			sqy_s2 <= sqy_c;
			rsq_s2 <= rsq_c;
			tag_s2 <= tag_s1;
		end
	end

	// ---------------- Stage 3: squared distance against squared radius ----------------
	// The sum stays below 2^64 for any input, so it needs no carry bit.
	logic [63:0]      dsq_c;
	logic [RAD_W-1:0] dsq_s3;
	tag_t             tag_s3_c;
	tag_t             tag_s3;
	assign dsq_c = sqx_s2 + sqy_s2;
	always_comb begin
		tag_s3_c          = tag_s2;
		tag_s3_c.hit      = dsq_c <= 64'(rsq_s2);
		tag_s3_c.interior = dsq_c == '0;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_s3 <= dsq_c[RAD_W-1:0];
			tag_s3 <= tag_s3_c;
		end
	end

	// ---------------- Square-root chain: one root bit per cell ----------------
	// Only a hit needs the root, and then the radicand is at most the radius squared.
	logic [REM_W-1:0] sq_rem  [SQ_CELLS+1];
	logic [LEN_W-1:0] sq_root [SQ_CELLS+1];
	logic [RAD_W-1:0] sq_rad  [SQ_CELLS+1];
	tag_t             sq_tag  [SQ_CELLS];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = dsq_s3;

	for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
		acc_sqrt_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.rad_in   (sq_rad[k]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1]),
			.rad_out  (sq_rad[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_tag[k] <= (k == 0) ? tag_s3 : sq_tag[(k == 0) ? 0 : k-1];
			end
		end
	end

	// ---------------- Stage 4: numerators for the normal ----------------
	// Numerator is |d| * 2^FRAC_BITS plus half the length, for round to nearest.
	logic [NUM_W-1:0] numx_c, numy_c;
	logic [LEN_W-1:0] len_c;
	logic [NUM_W-1:0] numx_s4, numy_s4;
	tag_t             tag_s4_c;
	tag_t             tag_s4;
	assign len_c  = sq_root[SQ_CELLS];
	assign numx_c = NUM_W'({sq_tag[SQ_CELLS-1].adx, {FRAC_BITS{1'b0}}}) + NUM_W'(len_c >> 1);
	assign numy_c = NUM_W'({sq_tag[SQ_CELLS-1].ady, {FRAC_BITS{1'b0}}}) + NUM_W'(len_c >> 1);
	always_comb begin
		tag_s4_c     = sq_tag[SQ_CELLS-1];
		tag_s4_c.len = len_c;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			numx_s4 <= numx_c;
			numy_s4 <= numy_c;
			tag_s4  <= tag_s4_c;
		end
	end

	// ---------------- Divider chains: one quotient bit per cell ----------------
	// The quotient fits in Q_BITS bits because each offset never exceeds the length.
	logic [LEN_W-1:0]  dvx [DIV_CELLS+1];
	logic [LEN_W-1:0]  rmx [DIV_CELLS+1];
	logic [Q_BITS-1:0] lwx [DIV_CELLS+1];
	logic [Q_BITS-1:0] qtx [DIV_CELLS+1];
	logic [LEN_W-1:0]  dvy [DIV_CELLS+1];
	logic [LEN_W-1:0]  rmy [DIV_CELLS+1];
	logic [Q_BITS-1:0] lwy [DIV_CELLS+1];
	logic [Q_BITS-1:0] qty [DIV_CELLS+1];
	tag_t              dv_tag [DIV_CELLS];

	assign dvx[0] = tag_s4.len;
	assign rmx[0] = numx_s4[NUM_W-1:Q_BITS];
	assign lwx[0] = numx_s4[Q_BITS-1:0];
	assign qtx[0] = '0;
	assign dvy[0] = tag_s4.len;
	assign rmy[0] = numy_s4[NUM_W-1:Q_BITS];
	assign lwy[0] = numy_s4[Q_BITS-1:0];
	assign qty[0] = '0;

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
		acc_div_cell u_cell_x (
			.clk         (clk),
			.en          (adv),
			.divisor_in  (dvx[k]),
			.rem_in      (rmx[k]),
			.low_in      (lwx[k]),
			.quot_in     (qtx[k]),
			.divisor_out (dvx[k+1]),
			.rem_out     (rmx[k+1]),
			.low_out     (lwx[k+1]),
			.quot_out    (qtx[k+1])
		);
		acc_div_cell u_cell_y (
			.clk         (clk),
			.en          (adv),
			.divisor_in  (dvy[k]),
			.rem_in      (rmy[k]),
			.low_in      (lwy[k]),
			.quot_in     (qty[k]),
			.divisor_out (dvy[k+1]),
			.rem_out     (rmy[k+1]),
			.low_out     (lwy[k+1]),
			.quot_out    (qty[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_tag[k] <= (k == 0) ? tag_s4 : dv_tag[(k == 0) ? 0 : k-1];
			end
		end
	end

	// ---------------- Valid line for the whole pipeline ----------------
	localparam int VLEN = 4 + SQ_CELLS + DIV_CELLS;
	logic [VLEN-1:0] valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[VLEN-2:0], s_tvalid};
		end
	end

	// ---------------- Output register ----------------
	tag_t                     ft;
	logic [DEPTH_W-1:0]       depth_c;
	logic signed [NORM_W-1:0] nx_c, ny_c, qx, qy;
	assign ft = dv_tag[DIV_CELLS-1];
	assign qx = NORM_W'(qtx[DIV_CELLS]);
	assign qy = NORM_W'(qty[DIV_CELLS]);

	always_comb begin
		depth_c = '0;
		nx_c    = '0;
		ny_c    = '0;
		if (ft.hit) begin
			if (ft.interior) begin
				depth_c = ft.in_depth;
				nx_c    = ft.in_nx;
				ny_c    = ft.in_ny;
			end else begin
				depth_c = DEPTH_W'(ft.radius - ft.len);
				nx_c    = ft.neg_x ? -qx : qx;
				ny_c    = ft.neg_y ? -qy : qy;
			end
		end
	end

	logic [DEPTH_W-1:0] depth_q;
	logic [NORM_W-1:0]  nx_q, ny_q;
	logic               hit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_q[VLEN-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			depth_q <= depth_c;
			nx_q    <= nx_c;
			ny_q    <= ny_c;
			hit_q   <= ft.hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, ny_q, nx_q, depth_q};
	assign m_tuser  = hit_q;

	// ---------------- Assertions ----------------
	// The x normal of a hit stays within one unit in either direction.
	logic nx_ok;
	assign nx_ok = $signed(nx_q) <= $signed(NORM_ONE) && $signed(nx_q) >= -$signed(NORM_ONE);

	`ACC_CHECK(a_nohit_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "miss with nonzero data")
	`ACC_CHECK(a_norm_range, (m_tvalid && m_tuser[0]) |-> nx_ok, "normal x out of range")
	`ACC_CHECK_ALWAYS(a_ready, s_tready == (!m_tvalid || m_tready), "ready does not follow output")

endmodule
